// ===== sv/positional_list_engine_core_assert.svh =====
// Assertion macros shared by the list engine RTL.
`ifndef POSITIONAL_LIST_ENGINE_CORE_ASSERT_SVH
`define POSITIONAL_LIST_ENGINE_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// Check that a condition holds at every clock edge outside reset.
`define PLE_ASSERT(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a trigger implies a consequent sequence.
`define PLE_ASSERT_IMPL(lbl, clk, rst_n, trig, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> cons) else $error(msg);

`else

`define PLE_ASSERT(lbl, clk, rst_n, cond, msg)
`define PLE_ASSERT_IMPL(lbl, clk, rst_n, trig, cons, msg)

`endif

`endif

// ===== sv/ple_pkg.sv =====
`timescale 1ns / 1ps

package ple_pkg;

  localparam int CMD_W    = 2;
  localparam int POS_W    = 7;
  localparam int VAL_W    = 32;
  localparam int LEN_W    = 7;
  localparam int S_DATA_W = 40;
  localparam int M_DATA_W = 48;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_GET    = 2'd2,
    CMD_LOCATE = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_WRITE,
    ST_DONE
  } state_e;

  // Result item, packed so that success sits in the lowest bit.
  typedef struct packed {
    logic [LEN_W-1:0]        list_length;
    logic [POS_W-1:0]        found_position;
    logic signed [VAL_W-1:0] read_value;
    logic                    success;
  } res_t;

endpackage

// ===== sv/ple_store.sv =====
`timescale 1ns / 1ps

module ple_store #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int DW    = 32
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/positional_list_engine_core.sv =====
`timescale 1ns / 1ps
// Channel   Dir  Handshake                       Payload
// s_axis    in   s_axis_tvalid_i/s_axis_tready_o tdata: position, value; tuser: command
// m_axis    out  m_axis_tvalid_o/m_axis_tready_i tdata: success, read_value,
//                                                 found_position, list_length
//
// One item at a time; the list lives in a single-port-read, single-port-write RAM.
// Insert, delete, get and locate walk the RAM in ST_RUN (insert then writes the new
// value in ST_WRITE); a rejected item goes straight to ST_DONE. The shift and scan
// move one entry a cycle through the RAM read port, which is registered; locate stops at its first match.
// Reset clears the length and control state; store contents stay undefined, no clearing pass.
// A result waiting in the output register holds off only the finish of the next item.

`include "positional_list_engine_core_assert.svh"

module positional_list_engine_core
  import ple_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // [6:0] position, [38:7] value, [39] zero
  input  logic [S_DATA_W-1:0] s_axis_tdata_i,
  // [1:0] command
  input  logic [CMD_W-1:0]    s_axis_tuser_i,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // [0] success, [32:1] read_value, [39:33] found_position, [46:40] list_length,
  // [47] zero
  output logic [M_DATA_W-1:0] m_axis_tdata_o
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = ((CW > POS_W) ? CW : POS_W) + 1;

  state_e           state_q, state_d;
  cmd_e             cmd_q, cmd_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic [VAL_W-1:0] val_q, val_d;
  logic [AW-1:0]    addr_q, addr_d;
  logic [AW-1:0]    pend_addr_q, pend_addr_d;
  logic [CW-1:0]    rem_q, rem_d;
  logic             pend_q, pend_d;
  logic             first_q, first_d;
  logic [CW-1:0]    count_q, count_d;
  logic             ok_q, ok_d;
  logic [VAL_W-1:0] rdv_q, rdv_d;
  logic [POS_W-1:0] found_q, found_d;
  logic             m_valid_q, m_valid_d;
  res_t             m_data_q, m_data_d;

  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [VAL_W-1:0] mem_wdata;
  logic             mem_re;
  logic [AW-1:0]    mem_raddr;
  logic [VAL_W-1:0] mem_rdata;

  cmd_e             cmd_in;
  logic [PW-1:0]    pos_w;
  logic [PW-1:0]    cnt_w;
  logic             ins_ok;
  logic             rng_ok;
  logic             hit;
  logic             s_acc;

  assign cmd_in = cmd_e'(s_axis_tuser_i);
  assign pos_w  = PW'(s_axis_tdata_i[POS_W-1:0]);
  assign cnt_w  = PW'(count_q);
  assign ins_ok = (pos_w != '0) && (pos_w <= cnt_w + PW'(1)) && (cnt_w < PW'(CAPACITY));
  assign rng_ok = (pos_w != '0) && (pos_w <= cnt_w);

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign s_acc           = s_axis_tvalid_i && s_axis_tready_o;
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {1'b0, m_data_q};

  ple_store #(
    .DEPTH (CAPACITY),
    .AW    (AW),
    .DW    (VAL_W)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    pos_d       = pos_q;
    val_d       = val_q;
    addr_d      = addr_q;
    pend_addr_d = pend_addr_q;
    rem_d       = rem_q;
    pend_d      = pend_q;
    first_d     = first_q;
    count_d     = count_q;
    ok_d        = ok_q;
    rdv_d       = rdv_q;
    found_d     = found_q;
    m_valid_d   = m_valid_q;
    m_data_d    = m_data_q;
    mem_we      = 1'b0;
    mem_waddr   = '0;
    mem_wdata   = '0;
    mem_re      = 1'b0;
    mem_raddr   = '0;
    hit         = 1'b0;

    if (m_valid_q && m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          cmd_d   = cmd_in;
          pos_d   = s_axis_tdata_i[POS_W-1:0];
          val_d   = s_axis_tdata_i[POS_W +: VAL_W];
          ok_d    = 1'b0;
          rdv_d   = '0;
          found_d = '0;
          pend_d  = 1'b0;
          first_d = 1'b1;
          state_d = ST_DONE;
          case (cmd_in)
            CMD_INSERT: begin
              if (ins_ok) begin
                ok_d    = 1'b1;
                count_d = count_q + CW'(1);
                rem_d   = CW'(cnt_w - pos_w + PW'(1));
                addr_d  = AW'(cnt_w - PW'(1));
                state_d = ST_RUN;
              end
            end
            CMD_DELETE: begin
              if (rng_ok) begin
                ok_d    = 1'b1;
                count_d = count_q - CW'(1);
                rem_d   = CW'(cnt_w - pos_w + PW'(1));
                addr_d  = AW'(pos_w - PW'(1));
                state_d = ST_RUN;
              end
            end
            CMD_GET: begin
              if (rng_ok) begin
                ok_d    = 1'b1;
                rem_d   = CW'(1);
                addr_d  = AW'(pos_w - PW'(1));
                state_d = ST_RUN;
              end
            end
            CMD_LOCATE: begin
              rem_d   = count_q;
              addr_d  = '0;
              state_d = ST_RUN;
            end
            default: begin
              state_d = ST_DONE;
            end
          endcase
        end
      end

      ST_RUN: begin
        // Retire the entry read last cycle.
        if (pend_q) begin
          first_d = 1'b0;
          case (cmd_q)
            CMD_INSERT: begin
              mem_we    = 1'b1;
              mem_waddr = pend_addr_q + AW'(1);
              mem_wdata = mem_rdata;
            end
            CMD_DELETE: begin
              if (first_q) begin
                rdv_d = mem_rdata;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = pend_addr_q - AW'(1);
                mem_wdata = mem_rdata;
              end
            end
            CMD_GET: begin
              rdv_d = mem_rdata;
            end
            CMD_LOCATE: begin
              if (mem_rdata == val_q) begin
                hit     = 1'b1;
                ok_d    = 1'b1;
                found_d = POS_W'(PW'(pend_addr_q) + PW'(1));
              end
            end
            default: begin
              hit = 1'b0;
            end
          endcase
        end

        // Issue the next read, or wrap up once the walk is done.
        if (hit) begin
          pend_d  = 1'b0;
          rem_d   = '0;
          state_d = ST_DONE;
        end else if (rem_q != '0) begin
          mem_re      = 1'b1;
          mem_raddr   = addr_q;
          pend_addr_d = addr_q;
          pend_d      = 1'b1;
          rem_d       = rem_q - CW'(1);
          addr_d      = (cmd_q == CMD_INSERT) ? addr_q - AW'(1) : addr_q + AW'(1);
        end else begin
          pend_d  = 1'b0;
          state_d = (cmd_q == CMD_INSERT) ? ST_WRITE : ST_DONE;
        end
      end

      ST_WRITE: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(PW'(pos_q) - PW'(1));
        mem_wdata = val_q;
        state_d   = ST_DONE;
      end

      ST_DONE: begin
        if (!m_valid_q || m_axis_tready_i) begin
          m_valid_d               = 1'b1;
          m_data_d.success        = ok_q;
          m_data_d.read_value     = rdv_q;
          m_data_d.found_position = found_q;
          m_data_d.list_length    = LEN_W'(count_q);
          state_d                 = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      pend_q    <= 1'b0;
      count_q   <= '0;
      m_valid_q <= 1'b0;
      rem_q     <= '0;
    end else begin
      state_q   <= state_d;
      pend_q    <= pend_d;
      count_q   <= count_d;
      m_valid_q <= m_valid_d;
      rem_q     <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    pos_q       <= pos_d;
    val_q       <= val_d;
    addr_q      <= addr_d;
    pend_addr_q <= pend_addr_d;
    first_q     <= first_d;
    ok_q        <= ok_d;
    rdv_q       <= rdv_d;
    found_q     <= found_d;
    m_data_q    <= m_data_d;
  end

  `PLE_ASSERT(a_no_rw_clash, clk_i, rst_ni, !(mem_we && mem_re && (mem_waddr == mem_raddr)), "read and write hit the same entry")
  `PLE_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= CW'(CAPACITY), "length above capacity")
  `PLE_ASSERT_IMPL(a_full_insert, clk_i, rst_ni, s_acc && (cmd_in == CMD_INSERT) && (cnt_w == PW'(CAPACITY)), ##1 (count_q == CW'(CAPACITY)), "insert into full list changed length")
  `PLE_ASSERT_IMPL(a_done_loads, clk_i, rst_ni, (state_q == ST_DONE) && (!m_valid_q || m_axis_tready_i), ##1 (m_valid_q && (state_q == ST_IDLE)), "finished item not presented")

endmodule

// ===== tb/sv/list_result_checker.sv =====
`timescale 1ns / 1ps

module list_result_checker
  import ple_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  input  logic                s_axis_tready_i,
  // [6:0] position, [38:7] value, [39] zero
  input  logic [S_DATA_W-1:0] s_axis_tdata_i,
  // [1:0] command
  input  logic [CMD_W-1:0]    s_axis_tuser_i,
  input  logic                m_axis_tvalid_i,
  input  logic                m_axis_tready_i,
  // [0] success, [32:1] read_value, [39:33] found_position, [46:40] list_length,
  // [47] zero
  input  logic [M_DATA_W-1:0] m_axis_tdata_i,
  output int                  fail_count_o,
  output int                  pending_o,
  output int                  checked_o
);

  logic signed [VAL_W-1:0] list_mem [0:CAPACITY-1];
  int unsigned             list_len;
  res_t                    expected_results[$];

  // Apply one command to the shadow list and return the result it should produce.
  function automatic res_t apply_list_command(cmd_e cmd, logic [POS_W-1:0] pos,
                                              logic signed [VAL_W-1:0] val);
    res_t        res;
    int unsigned p;
    int unsigned k;
    res = '0;
    p   = 32'(pos);
    case (cmd)
      CMD_INSERT: begin
        if (p >= 1 && p <= list_len + 1 && list_len < CAPACITY) begin
          for (k = list_len; k > p - 1; k--) list_mem[k] = list_mem[k-1];
          list_mem[p-1] = val;
          list_len++;
          res.success = 1'b1;
        end
      end
      CMD_DELETE: begin
        if (p >= 1 && p <= list_len) begin
          res.read_value = list_mem[p-1];
          for (k = p - 1; k + 1 < list_len; k++) list_mem[k] = list_mem[k+1];
          list_len--;
          res.success = 1'b1;
        end
      end
      CMD_GET: begin
        if (p >= 1 && p <= list_len) begin
          res.read_value = list_mem[p-1];
          res.success    = 1'b1;
        end
      end
      default: begin
        // first match wins, so duplicates report the lowest position
        for (k = 0; k < list_len; k++) begin
          if (list_mem[k] == val) begin
            res.found_position = POS_W'(k + 1);
            res.success        = 1'b1;
            break;
          end
        end
      end
    endcase
    res.list_length = LEN_W'(list_len);
    return res;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("[%0t] result %0d: %s got %0h, expected %0h", $time, checked_o, what,
             got, want);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    res_t got;
    res_t want;
    if (!rst_ni) begin
      list_len = 0;
      expected_results.delete();
      fail_count_o = 0;
      checked_o    = 0;
      pending_o    = 0;
    end else begin
      // retire the output side first: a result never belongs to an item taken this edge
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got = res_t'(m_axis_tdata_i[$bits(res_t)-1:0]);
        if (expected_results.size() == 0) begin
          $display("[%0t] result with nothing outstanding: %0h", $time, got);
          fail_count_o++;
        end else begin
          want = expected_results.pop_front();
          if (got.success !== want.success)
            report_mismatch("success", got.success, want.success);
          if (got.read_value !== want.read_value)
            report_mismatch("read_value", got.read_value, want.read_value);
          if (got.found_position !== want.found_position)
            report_mismatch("found_position", got.found_position, want.found_position);
          if (got.list_length !== want.list_length)
            report_mismatch("list_length", got.list_length, want.list_length);
        end
        checked_o++;
      end
      if (s_axis_tvalid_i && s_axis_tready_i)
        expected_results.push_back(apply_list_command(cmd_e'(s_axis_tuser_i),
                                                      s_axis_tdata_i[POS_W-1:0],
                                                      s_axis_tdata_i[POS_W+VAL_W-1:POS_W]));
      pending_o = expected_results.size();
    end
  end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import ple_pkg::*;

  localparam int CAPACITY    = 64;
  localparam int CYCLE_LIMIT = 500000;
  localparam int DRAIN_WAIT  = 120;

  // receiver stall patterns
  localparam int RX_OPEN   = 0;
  localparam int RX_RANDOM = 1;
  localparam int RX_CHOKED = 2;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid_i = 1'b0;
  logic                s_axis_tready_o;
  logic [S_DATA_W-1:0] s_axis_tdata_i = '0;
  logic [CMD_W-1:0]    s_axis_tuser_i = '0;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;
  logic [M_DATA_W-1:0] m_axis_tdata_o;

  int fail_count;
  int pending;
  int checked;
  int cycle_cnt = 0;
  int items_sent = 0;
  int burst_left = 0;
  int rx_mode = RX_OPEN;
  int rx_left = 0;
  int len_seen = 0;
  int peak_len = 0;
  int full_hits = 0;

  logic signed [VAL_W-1:0] value_pool [0:7] = '{
    32'sh0000_0000, 32'sh0000_0001, -32'sh1, 32'sh8000_0000,
    32'sh7fff_ffff, 32'sh5555_5555, 32'shaaaa_aaaa, 32'sh0000_002a
  };

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  positional_list_engine_core #(.CAPACITY(CAPACITY)) dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid_i,
    .s_axis_tready_o,
    .s_axis_tdata_i,
    .s_axis_tuser_i,
    .m_axis_tvalid_o,
    .m_axis_tready_i,
    .m_axis_tdata_o
  );

  list_result_checker #(.CAPACITY(CAPACITY)) u_checker (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid_i,
    .s_axis_tready_i(s_axis_tready_o),
    .s_axis_tdata_i,
    .s_axis_tuser_i,
    .m_axis_tvalid_i(m_axis_tvalid_o),
    .m_axis_tready_i,
    .m_axis_tdata_i(m_axis_tdata_o),
    .fail_count_o(fail_count),
    .pending_o(pending),
    .checked_o(checked)
  );

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt, pending);
      $display("positional_list_engine_core verification failed");
      $finish;
    end
  end

  // Receiver: switch between stall patterns; track the length reported by results
  always @(posedge clk_i or negedge rst_ni) begin
    res_t seen;
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode = $urandom_range(RX_OPEN, RX_CHOKED);
        rx_left = $urandom_range(20, 200);
      end else begin
        rx_left--;
      end
      case (rx_mode)
        RX_OPEN:   m_axis_tready_i <= 1'b1;
        RX_RANDOM: m_axis_tready_i <= 1'($urandom_range(0, 1));
        default:   m_axis_tready_i <= ($urandom_range(0, 3) == 0);
      endcase
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        seen     = res_t'(m_axis_tdata_o[$bits(res_t)-1:0]);
        len_seen = int'(seen.list_length);
        if (len_seen > peak_len) peak_len = len_seen;
        if (len_seen == CAPACITY) full_hits++;
      end
    end
  end

  // Present one item and hold it until taken; open a new burst after a random gap.
  task automatic send_item(cmd_e cmd, logic [POS_W-1:0] pos, logic signed [VAL_W-1:0] val);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_axis_tvalid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {1'b0, val, pos};
    s_axis_tuser_i  <= cmd;
    do @(posedge clk_i); while (!s_axis_tready_o);
    items_sent++;
  endtask

  function automatic logic signed [VAL_W-1:0] pick_value();
    if ($urandom_range(0, 1) == 0) return value_pool[$urandom_range(0, 7)];
    return $urandom;
  endfunction

  function automatic logic [POS_W-1:0] pick_pos(cmd_e cmd);
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return '0;
    if (r < 12) return POS_W'($urandom_range(0, 127));
    if (cmd == CMD_INSERT) return POS_W'($urandom_range(1, len_seen + 1));
    return POS_W'($urandom_range(1, (len_seen > 0) ? len_seen : 1));
  endfunction

  // Random items; ins_pct weights inserts, del_pct deletes, the rest split get/locate
  task automatic random_phase(int n, int ins_pct, int del_pct);
    cmd_e cmd;
    int   r;
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < ins_pct) cmd = CMD_INSERT;
      else if (r < ins_pct + del_pct) cmd = CMD_DELETE;
      else if (r[0]) cmd = CMD_GET;
      else cmd = CMD_LOCATE;
      send_item(cmd, pick_pos(cmd), pick_value());
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // empty list and out-of-range positions
    send_item(CMD_LOCATE, 7'd0, 32'sd0);
    send_item(CMD_GET,    7'd1, 32'sd0);
    send_item(CMD_DELETE, 7'd1, 32'sd0);
    send_item(CMD_INSERT, 7'd0, 32'sd5);
    send_item(CMD_INSERT, 7'd2, 32'sd5);
    // build [-1, 0, min, max, -1]
    send_item(CMD_INSERT, 7'd1, 32'sh8000_0000);
    send_item(CMD_INSERT, 7'd2, 32'sh7fff_ffff);
    send_item(CMD_INSERT, 7'd1, -32'sh1);
    send_item(CMD_INSERT, 7'd4, -32'sh1);
    send_item(CMD_INSERT, 7'd2, 32'sd0);
    send_item(CMD_LOCATE, 7'd0, -32'sh1);
    send_item(CMD_LOCATE, 7'd127, 32'sh7fff_ffff);
    send_item(CMD_LOCATE, 7'd0, 32'sd12345);
    send_item(CMD_GET,    7'd0, 32'sd0);
    send_item(CMD_GET,    7'd5, 32'sd0);
    send_item(CMD_GET,    7'd6, 32'sd0);
    send_item(CMD_GET,    7'd127, -32'sh1);
    send_item(CMD_DELETE, 7'd6, 32'sd0);
    send_item(CMD_DELETE, 7'd0, 32'sd0);
    send_item(CMD_INSERT, 7'd127, 32'sh5555_5555);
    send_item(CMD_DELETE, 7'd3, 32'sd0);
    send_item(CMD_DELETE, 7'd4, 32'sd0);
    send_item(CMD_DELETE, 7'd1, 32'sd0);
    send_item(CMD_GET,    7'd1, 32'sd0);

    // fill past capacity, churn, then drain to empty
    random_phase(200, 85, 5);
    random_phase(200, 30, 25);
    random_phase(200, 5, 75);
    s_axis_tvalid_i <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("sent %0d commands, checked %0d results in %0d cycles", items_sent, checked,
             cycle_cnt);
    $display("longest list seen %0d of %0d, full-store results %0d", peak_len, CAPACITY,
             full_hits);
    if (fail_count == 0) begin
      $display("positional_list_engine_core verification clean");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("positional_list_engine_core verification failed");
    end
    $finish;
  end

endmodule

// ===== positional_list_engine_core.f =====
+incdir+sv
sv/ple_pkg.sv
sv/ple_store.sv
sv/positional_list_engine_core.sv
tb/sv/list_result_checker.sv
tb/sv/tb.sv
